### rtl/xcr_pkg.sv
// ----------------------------------------------------------------------------
// xcr_pkg
// Types, codes and helpers shared by the XMODEM checksum receiver modules.
// ----------------------------------------------------------------------------
package xcr_pkg;

    localparam int BLOCK_BYTES = 128;
    localparam int CFG_ADDR_W  = 3;
    localparam int CFG_DATA_W  = 16;

    localparam logic [7:0] BYTE_NUL = 8'h00;
    localparam logic [7:0] BYTE_SOH = 8'h01;
    localparam logic [7:0] BYTE_EOT = 8'h04;
    localparam logic [7:0] BYTE_ACK = 8'h06;
    localparam logic [7:0] BYTE_NAK = 8'h15;
    localparam logic [7:0] BYTE_CAN = 8'h18;

    localparam logic [CFG_ADDR_W-1:0] REG_LEAD_TIMEOUT = 3'd0;
    localparam logic [CFG_ADDR_W-1:0] REG_BYTE_TIMEOUT = 3'd1;
    localparam logic [CFG_ADDR_W-1:0] REG_QUIET        = 3'd2;
    localparam logic [CFG_ADDR_W-1:0] REG_MAX_RETRIES  = 3'd3;
    localparam logic [CFG_ADDR_W-1:0] REG_TRAILER      = 3'd4;

    localparam logic [15:0] RST_LEAD_TIMEOUT = 16'd10000;
    localparam logic [15:0] RST_BYTE_TIMEOUT = 16'd1000;
    localparam logic [15:0] RST_QUIET        = 16'd500;
    localparam logic [3:0]  RST_MAX_RETRIES  = 4'd10;
    localparam logic [7:0]  RST_TRAILER      = 8'd24;

    typedef enum logic [1:0] {
        OP_START,
        OP_BYTE,
        OP_TICK,
        OP_ABORT
    } op_t;

    typedef enum logic [1:0] {
        KIND_TX,
        KIND_PAYLOAD,
        KIND_VERDICT,
        KIND_END
    } kind_t;

    typedef enum logic [2:0] {
        ST_SUCCESS,
        ST_RETRY_LIMIT,
        ST_PEER_CANCEL,
        ST_OUT_OF_SEQ,
        ST_INTERRUPTED
    } end_status_t;

    typedef enum logic [3:0] {
        PH_IDLE,
        PH_LEAD,
        PH_HNUM,
        PH_HCOMP,
        PH_DATA,
        PH_SUM,
        PH_RETRY,
        PH_CAN_RETRY,
        PH_CAN_SEQ,
        PH_CAN_INT
    } phase_t;

    typedef enum logic [1:0] {
        ACT_NONE,
        ACT_NAK,
        ACT_CAN,
        ACT_TRAILER
    } action_t;

    typedef struct packed {
        logic [15:0] lead_timeout_ticks;
        logic [15:0] byte_timeout_ticks;
        logic [15:0] quiet_ticks;
        logic [3:0]  max_retries;
        logic [7:0]  cancel_trailer;
    } cfg_t;

    typedef struct packed {
        op_t        operation;
        logic [7:0] rx_byte;
    } item_t;

    typedef struct packed {
        kind_t       kind;
        logic [7:0]  value;
        logic [6:0]  index;
        end_status_t status;
        logic        last;
    } result_t;

    typedef struct packed {
        logic    two;
        result_t first;
        result_t second;
    } result_pair_t;

    function automatic result_t tx_result(input logic [7:0] b);
        result_t r;
        r        = '0;
        r.kind   = KIND_TX;
        r.value  = b;
        r.status = ST_SUCCESS;
        return r;
    endfunction

    function automatic result_t verdict_result(input logic commit);
        result_t r;
        r        = '0;
        r.kind   = KIND_VERDICT;
        r.value  = {7'd0, commit};
        r.status = ST_SUCCESS;
        return r;
    endfunction

    function automatic result_t end_result(input end_status_t st);
        result_t r;
        r        = '0;
        r.kind   = KIND_END;
        r.status = st;
        return r;
    endfunction

    function automatic result_t payload_result(input logic [7:0] b, input logic [6:0] idx);
        result_t r;
        r        = '0;
        r.kind   = KIND_PAYLOAD;
        r.value  = b;
        r.index  = idx;
        r.status = ST_SUCCESS;
        return r;
    endfunction

endpackage

### rtl/xcr_in_stage.sv
// ----------------------------------------------------------------------------
// xcr_in_stage
// Input register: holds one accepted transfer until the core takes it.
// ----------------------------------------------------------------------------
module xcr_in_stage (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_tvalid,
    output logic                s_tready,
    input  logic [7:0]          s_tdata,   // [7:0] rx_byte
    input  logic [1:0]          s_tuser,   // [1:0] operation
    input  logic                take,
    output logic                item_valid,
    output xcr_pkg::item_t      item
);
    import xcr_pkg::*;

    logic  valid_reg;
    item_t item_reg;

    assign s_tready   = !valid_reg || take;
    assign item_valid = valid_reg;
    assign item       = item_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (s_tready) begin
            valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            item_reg.operation <= op_t'(s_tuser);
            item_reg.rx_byte   <= s_tdata;
        end
    end

endmodule

### rtl/xcr_core.sv
// ----------------------------------------------------------------------------
// xcr_core
// Protocol state and per-item decode: one item in, up to two results out.
// ----------------------------------------------------------------------------
module xcr_core (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 fire,
    input  xcr_pkg::item_t       item,
    input  xcr_pkg::cfg_t        cfg,
    output logic                 push,
    output xcr_pkg::result_pair_t pair
);
    import xcr_pkg::*;

    phase_t      phase_reg, phase_next;
    action_t     act_reg, act_next;
    logic [15:0] tick_reg, tick_next;
    logic [3:0]  retry_reg, retry_next;
    logic [7:0]  good_reg, good_next;
    logic [7:0]  hnum_reg, hnum_next;
    logic [7:0]  hcomp_reg, hcomp_next;
    logic [7:0]  idx_reg, idx_next;
    logic [7:0]  sum_reg, sum_next;

    logic [15:0] tick_inc;
    logic [3:0]  retry_inc;
    logic [7:0]  idx_inc;
    logic [7:0]  good_inc;
    logic [1:0]  count;
    result_t     r0, r1;
    end_status_t cancel_status;
    logic [7:0]  b;

    assign b         = item.rx_byte;
    assign tick_inc  = (tick_reg == 16'hFFFF) ? tick_reg : tick_reg + 16'd1;
    assign retry_inc = (retry_reg == 4'hF) ? retry_reg : retry_reg + 4'd1;
    assign idx_inc   = idx_reg + 8'd1;
    assign good_inc  = good_reg + 8'd1;

    always_comb begin
        unique case (phase_reg)
            PH_CAN_RETRY: cancel_status = ST_RETRY_LIMIT;
            PH_CAN_SEQ:   cancel_status = ST_OUT_OF_SEQ;
            default:      cancel_status = ST_INTERRUPTED;
        endcase
    end

    always_comb begin
        phase_next = phase_reg;
        act_next   = act_reg;
        tick_next  = tick_reg;
        retry_next = retry_reg;
        good_next  = good_reg;
        hnum_next  = hnum_reg;
        hcomp_next = hcomp_reg;
        idx_next   = idx_reg;
        sum_next   = sum_reg;
        count      = 2'd0;
        r0         = '0;
        r1         = '0;

        unique case (item.operation)
            OP_START: begin
                if (phase_reg == PH_IDLE) begin
                    retry_next = 4'd0;
                    good_next  = 8'd0;
                    r0         = tx_result(BYTE_NAK);
                    count      = 2'd1;
                    phase_next = PH_LEAD;
                    act_next   = ACT_NONE;
                    tick_next  = 16'd0;
                end
            end
            OP_BYTE: begin
                unique case (phase_reg)
                    PH_LEAD: begin
                        priority if (b == BYTE_NUL) begin
                        end else if (b == BYTE_EOT) begin
                            r0         = tx_result(BYTE_ACK);
                            r1         = end_result(ST_SUCCESS);
                            count      = 2'd2;
                            phase_next = PH_IDLE;
                            act_next   = ACT_NONE;
                            tick_next  = 16'd0;
                        end else if (b == BYTE_CAN) begin
                            r0         = end_result(ST_PEER_CANCEL);
                            count      = 2'd1;
                            phase_next = PH_IDLE;
                            act_next   = ACT_NONE;
                            tick_next  = 16'd0;
                        end else if (b == BYTE_SOH) begin
                            phase_next = PH_HNUM;
                            act_next   = ACT_NONE;
                            tick_next  = 16'd0;
                        end else begin
                            phase_next = PH_RETRY;
                            act_next   = ACT_NAK;
                            tick_next  = 16'd0;
                        end
                    end
                    PH_HNUM: begin
                        hnum_next  = b;
                        phase_next = PH_HCOMP;
                        act_next   = ACT_NONE;
                        tick_next  = 16'd0;
                    end
                    PH_HCOMP: begin
                        hcomp_next = b;
                        tick_next  = 16'd0;
                        if ((hnum_reg ^ b) != 8'hFF) begin
                            phase_next = PH_RETRY;
                            act_next   = ACT_NAK;
                        end else begin
                            idx_next   = 8'd0;
                            sum_next   = 8'd0;
                            phase_next = PH_DATA;
                            act_next   = ACT_NONE;
                        end
                    end
                    PH_DATA: begin
                        r0        = payload_result(b, idx_reg[6:0]);
                        count     = 2'd1;
                        sum_next  = sum_reg + b;
                        idx_next  = idx_inc;
                        tick_next = 16'd0;
                        if (idx_inc >= 8'(BLOCK_BYTES)) begin
                            phase_next = PH_SUM;
                        end
                    end
                    PH_SUM: begin
                        tick_next = 16'd0;
                        priority if (b != sum_reg) begin
                            r0         = verdict_result(1'b0);
                            count      = 2'd1;
                            phase_next = PH_RETRY;
                            act_next   = ACT_NAK;
                        end else if (hnum_reg == good_reg) begin
                            r0         = verdict_result(1'b0);
                            r1         = tx_result(BYTE_ACK);
                            count      = 2'd2;
                            retry_next = 4'd0;
                            phase_next = PH_LEAD;
                            act_next   = ACT_NONE;
                        end else if (hnum_reg == good_inc) begin
                            r0         = verdict_result(1'b1);
                            r1         = tx_result(BYTE_ACK);
                            count      = 2'd2;
                            good_next  = hnum_reg;
                            retry_next = 4'd0;
                            phase_next = PH_LEAD;
                            act_next   = ACT_NONE;
                        end else begin
                            r0         = verdict_result(1'b0);
                            count      = 2'd1;
                            phase_next = PH_CAN_SEQ;
                            act_next   = ACT_CAN;
                        end
                    end
                    PH_RETRY, PH_CAN_RETRY, PH_CAN_SEQ, PH_CAN_INT: begin
                        tick_next = 16'd0;
                    end
                    default: begin
                    end
                endcase
            end
            OP_TICK: begin
                unique case (phase_reg)
                    PH_LEAD: begin
                        tick_next = tick_inc;
                        if (tick_inc >= cfg.lead_timeout_ticks) begin
                            phase_next = PH_RETRY;
                            act_next   = ACT_NAK;
                            tick_next  = 16'd0;
                        end
                    end
                    PH_HNUM, PH_HCOMP: begin
                        tick_next = tick_inc;
                        if (tick_inc >= cfg.byte_timeout_ticks) begin
                            phase_next = PH_RETRY;
                            act_next   = ACT_NAK;
                            tick_next  = 16'd0;
                        end
                    end
                    PH_DATA, PH_SUM: begin
                        tick_next = tick_inc;
                        if (tick_inc >= cfg.byte_timeout_ticks) begin
                            r0         = verdict_result(1'b0);
                            count      = 2'd1;
                            phase_next = PH_RETRY;
                            act_next   = ACT_NAK;
                            tick_next  = 16'd0;
                        end
                    end
                    PH_RETRY, PH_CAN_RETRY, PH_CAN_SEQ, PH_CAN_INT: begin
                        tick_next = tick_inc;
                        if (tick_inc >= cfg.quiet_ticks) begin
                            tick_next = 16'd0;
                            unique case (act_reg)
                                ACT_NAK: begin
                                    r0         = tx_result(BYTE_NAK);
                                    count      = 2'd1;
                                    retry_next = retry_inc;
                                    if (retry_inc >= cfg.max_retries) begin
                                        phase_next = PH_CAN_RETRY;
                                        act_next   = ACT_CAN;
                                    end else begin
                                        phase_next = PH_LEAD;
                                        act_next   = ACT_NONE;
                                    end
                                end
                                ACT_CAN: begin
                                    r0       = tx_result(BYTE_CAN);
                                    count    = 2'd1;
                                    act_next = ACT_TRAILER;
                                end
                                default: begin
                                    r0         = tx_result(cfg.cancel_trailer);
                                    r1         = end_result(cancel_status);
                                    count      = 2'd2;
                                    phase_next = PH_IDLE;
                                    act_next   = ACT_NONE;
                                end
                            endcase
                        end
                    end
                    default: begin
                    end
                endcase
            end
            OP_ABORT: begin
                if (phase_reg == PH_LEAD || phase_reg == PH_HNUM || phase_reg == PH_HCOMP ||
                    phase_reg == PH_DATA || phase_reg == PH_SUM || phase_reg == PH_RETRY) begin
                    if (phase_reg == PH_DATA || phase_reg == PH_SUM) begin
                        r0    = verdict_result(1'b0);
                        count = 2'd1;
                    end
                    phase_next = PH_CAN_INT;
                    act_next   = ACT_CAN;
                    tick_next  = 16'd0;
                end
            end
            default: begin
            end
        endcase

        if (count == 2'd2) begin
            r1.last = 1'b1;
        end else begin
            r0.last = 1'b1;
        end
    end

    assign push        = fire && (count != 2'd0);
    assign pair.two    = (count == 2'd2);
    assign pair.first  = r0;
    assign pair.second = r1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= PH_IDLE;
            act_reg   <= ACT_NONE;
            tick_reg  <= 16'd0;
            retry_reg <= 4'd0;
            good_reg  <= 8'd0;
            hnum_reg  <= 8'd0;
            hcomp_reg <= 8'd0;
            idx_reg   <= 8'd0;
            sum_reg   <= 8'd0;
        end else if (fire) begin
            phase_reg <= phase_next;
            act_reg   <= act_next;
            tick_reg  <= tick_next;
            retry_reg <= retry_next;
            good_reg  <= good_next;
            hnum_reg  <= hnum_next;
            hcomp_reg <= hcomp_next;
            idx_reg   <= idx_next;
            sum_reg   <= sum_next;
        end
    end

endmodule

### rtl/xcr_out_fifo.sv
// ----------------------------------------------------------------------------
// xcr_out_fifo
// Two-entry buffer of result pairs, drained one result per transfer.
// ----------------------------------------------------------------------------
module xcr_out_fifo (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  push,
    input  xcr_pkg::result_pair_t pair,
    output logic                  full,
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [23:0]           m_tdata,   // [7:0] value, [14:8] index, [17:15] status
    output logic [1:0]            m_tuser,   // [1:0] kind
    output logic                  m_tlast
);
    import xcr_pkg::*;

    result_pair_t mem_reg [2];
    logic         wr_ptr_reg;
    logic         rd_ptr_reg;
    logic         sub_reg;
    logic [1:0]   level_reg;
    logic         pop;
    result_pair_t head;
    result_t      cur;

    assign head     = mem_reg[rd_ptr_reg];
    assign cur      = sub_reg ? head.second : head.first;
    assign m_tvalid = (level_reg != 2'd0);
    assign full     = (level_reg == 2'd2);
    assign pop      = m_tvalid && m_tready && (sub_reg || !head.two);

    assign m_tdata  = {6'd0, 3'(cur.status), cur.index, cur.value};
    assign m_tuser  = 2'(cur.kind);
    assign m_tlast  = cur.last;

    always_ff @(posedge aclk) begin
        if (push) begin
            mem_reg[wr_ptr_reg] <= pair;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            sub_reg    <= 1'b0;
            level_reg  <= 2'd0;
        end else begin
            if (push) begin
                wr_ptr_reg <= !wr_ptr_reg;
            end
            if (pop) begin
                rd_ptr_reg <= !rd_ptr_reg;
                sub_reg    <= 1'b0;
            end else if (m_tvalid && m_tready) begin
                sub_reg <= 1'b1;
            end
            unique case ({push, pop})
                2'b10:   level_reg <= level_reg + 2'd1;
                2'b01:   level_reg <= level_reg - 2'd1;
                default: level_reg <= level_reg;
            endcase
        end
    end

endmodule

### rtl/xmodem_checksum_receiver.sv
// ----------------------------------------------------------------------------
// xmodem_checksum_receiver
// XMODEM checksum-mode receiver: block parsing, ACK/NAK/CAN generation.
// ----------------------------------------------------------------------------
// One input transfer (start, line byte, timer tick or abort) is taken per
// clock. An item is registered on acceptance and decoded by the core once
// the result buffer has room; its results are written into a two-entry
// result buffer, from whose head the first result is offered. An item
// causes zero, one or two results; the result port delivers one per cycle
// while m_tready is high, so the sustained rate is one item per cycle while
// items produce at most one result each, and the input stalls only when the
// result buffer is full. Configuration writes are applied on the following
// edge and take effect for the next item.
module xmodem_checksum_receiver (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  logic [7:0]                      s_tdata,   // [7:0] rx_byte
    input  logic [1:0]                      s_tuser,   // [1:0] operation
    output logic                            m_tvalid,
    input  logic                            m_tready,
    output logic [23:0]                     m_tdata,   // [7:0] value, [14:8] index,
                                                       // [17:15] status
    output logic [1:0]                      m_tuser,   // [1:0] kind
    output logic                            m_tlast,
    input  logic                            cfg_we,
    input  logic [xcr_pkg::CFG_ADDR_W-1:0]  cfg_addr,
    input  logic [xcr_pkg::CFG_DATA_W-1:0]  cfg_wdata
);
    import xcr_pkg::*;

    cfg_t         cfg_reg;
    logic         item_valid;
    item_t        item;
    logic         fifo_full;
    logic         fire;
    logic         push;
    result_pair_t pair;

    assign fire = item_valid && !fifo_full;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.lead_timeout_ticks <= RST_LEAD_TIMEOUT;
            cfg_reg.byte_timeout_ticks <= RST_BYTE_TIMEOUT;
            cfg_reg.quiet_ticks        <= RST_QUIET;
            cfg_reg.max_retries        <= RST_MAX_RETRIES;
            cfg_reg.cancel_trailer     <= RST_TRAILER;
        end else if (cfg_we) begin
            unique case (cfg_addr)
                REG_LEAD_TIMEOUT: cfg_reg.lead_timeout_ticks <= cfg_wdata;
                REG_BYTE_TIMEOUT: cfg_reg.byte_timeout_ticks <= cfg_wdata;
                REG_QUIET:        cfg_reg.quiet_ticks        <= cfg_wdata;
                REG_MAX_RETRIES:  cfg_reg.max_retries        <= cfg_wdata[3:0];
                REG_TRAILER:      cfg_reg.cancel_trailer     <= cfg_wdata[7:0];
                default: begin
                end
            endcase
        end
    end

    xcr_in_stage u_in_stage (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tuser    (s_tuser),
        .take       (fire),
        .item_valid (item_valid),
        .item       (item)
    );

    xcr_core u_core (
        .aclk    (aclk),
        .aresetn (aresetn),
        .fire    (fire),
        .item    (item),
        .cfg     (cfg_reg),
        .push    (push),
        .pair    (pair)
    );

    xcr_out_fifo u_out_fifo (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .push     (push),
        .pair     (pair),
        .full     (fifo_full),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    a_end_is_last: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && (m_tuser == 2'(KIND_END)) |-> m_tlast)
        else $error("session end not marked last");

    a_payload_is_last: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && (m_tuser == 2'(KIND_PAYLOAD)) |-> m_tlast)
        else $error("payload byte not the only result of its item");

    a_verdict_bit: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && (m_tuser == 2'(KIND_VERDICT)) |-> (m_tdata[7:1] == 7'd0))
        else $error("verdict value out of range");

    a_stall_held: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_tready |-> item_valid && fifo_full)
        else $error("input stalled without a pending item");

endmodule

### tb/tb_xmodem_checksum_receiver.sv
// ----------------------------------------------------------------------------
// tb_xmodem_checksum_receiver
// Self-checking bench for the XMODEM checksum receiver. A queue of line
// events (start, bytes, ticks, aborts) feeds a bursty stream driver. Each
// accepted transfer steps a session predictor that queues the expected
// transmit bytes, payload bytes, verdicts and session ends. A monitor on the
// result stream compares every transfer field by field, under a receiver
// that stalls on its own pattern. Registers change only between phases.
// ----------------------------------------------------------------------------
module tb_xmodem_checksum_receiver;

    import xcr_pkg::*;

    localparam int CYCLE_LIMIT = 400_000;
    localparam int LONG_HOLD   = 400;

    logic                  aclk      = 1'b0;
    logic                  aresetn   = 1'b0;
    logic                  s_tvalid  = 1'b0;
    logic                  s_tready;
    logic [7:0]            s_tdata   = '0;
    logic [1:0]            s_tuser   = '0;
    logic                  m_tvalid;
    logic                  m_tready  = 1'b0;
    logic [23:0]           m_tdata;
    logic [1:0]            m_tuser;
    logic                  m_tlast;
    logic                  cfg_we    = 1'b0;
    logic [CFG_ADDR_W-1:0] cfg_addr  = '0;
    logic [CFG_DATA_W-1:0] cfg_wdata = '0;

    xmodem_checksum_receiver dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata)
    );

    always begin
        #2 aclk = 1'b1;
        #2 aclk = 1'b0;
    end

    // register copies
    logic [15:0] reg_lead    = RST_LEAD_TIMEOUT;
    logic [15:0] reg_byte    = RST_BYTE_TIMEOUT;
    logic [15:0] reg_quiet   = RST_QUIET;
    logic [3:0]  reg_retries = RST_MAX_RETRIES;
    logic [7:0]  reg_trailer = RST_TRAILER;

    // session state
    phase_t      ses_phase     = PH_IDLE;
    action_t     ses_action    = ACT_NONE;
    logic [15:0] ses_ticks     = '0;
    logic [3:0]  ses_retries   = '0;
    logic [7:0]  ses_last_good = '0;
    logic [7:0]  ses_hdr_num   = '0;
    logic [7:0]  ses_hdr_comp  = '0;
    logic [7:0]  ses_idx       = '0;
    logic [7:0]  ses_sum       = '0;

    item_t   line_items[$];
    result_t session_events[$];
    result_t step_events[$];

    int  items_pushed    = 0;
    int  items_accepted  = 0;
    int  results_checked = 0;
    int  blocks_committed = 0;
    int  sessions_closed = 0;
    int  errors          = 0;
    int  cycles          = 0;
    bit  offer_taken     = 1'b0;
    int  burst_left      = 0;
    int  gap_left        = 0;
    int  hold_requests   = 0;
    int  holds_served    = 0;
    int  hold_left       = 0;
    int  rx_mode         = 0;
    int  rx_mode_cnt     = 0;
    int  rx_stall_left   = 0;

    function automatic void add_event(kind_t k, logic [7:0] v, logic [6:0] ix,
                                      end_status_t st);
        result_t r;
        r.kind   = k;
        r.value  = v;
        r.index  = ix;
        r.status = st;
        r.last   = 1'b0;
        step_events.push_back(r);
        if (k == KIND_END)
            sessions_closed++;
        if (k == KIND_VERDICT && v[0])
            blocks_committed++;
    endfunction

    function automatic void enter_phase(phase_t p, action_t a);
        ses_phase  = p;
        ses_action = a;
        ses_ticks  = '0;
    endfunction

    function automatic bit tick_reaches(logic [15:0] lim);
        if (ses_ticks != 16'hFFFF)
            ses_ticks++;
        return ses_ticks >= lim;
    endfunction

    function automatic void advance_session(op_t op, logic [7:0] b);
        end_status_t st;
        step_events.delete();
        case (op)
            OP_START: begin
                if (ses_phase == PH_IDLE) begin
                    ses_retries   = '0;
                    ses_last_good = '0;
                    add_event(KIND_TX, BYTE_NAK, '0, ST_SUCCESS);
                    enter_phase(PH_LEAD, ACT_NONE);
                end
            end
            OP_BYTE: begin
                case (ses_phase)
                    PH_LEAD: begin
                        if (b == BYTE_EOT) begin
                            add_event(KIND_TX, BYTE_ACK, '0, ST_SUCCESS);
                            add_event(KIND_END, '0, '0, ST_SUCCESS);
                            enter_phase(PH_IDLE, ACT_NONE);
                        end else if (b == BYTE_CAN) begin
                            add_event(KIND_END, '0, '0, ST_PEER_CANCEL);
                            enter_phase(PH_IDLE, ACT_NONE);
                        end else if (b == BYTE_SOH) begin
                            enter_phase(PH_HNUM, ACT_NONE);
                        end else if (b != BYTE_NUL) begin
                            enter_phase(PH_RETRY, ACT_NAK);
                        end
                    end
                    PH_HNUM: begin
                        ses_hdr_num = b;
                        enter_phase(PH_HCOMP, ACT_NONE);
                    end
                    PH_HCOMP: begin
                        ses_hdr_comp = b;
                        if ((ses_hdr_num ^ ses_hdr_comp) != 8'hFF) begin
                            enter_phase(PH_RETRY, ACT_NAK);
                        end else begin
                            ses_idx = '0;
                            ses_sum = '0;
                            enter_phase(PH_DATA, ACT_NONE);
                        end
                    end
                    PH_DATA: begin
                        add_event(KIND_PAYLOAD, b, ses_idx[6:0], ST_SUCCESS);
                        ses_sum   = ses_sum + b;
                        ses_idx   = ses_idx + 8'd1;
                        ses_ticks = '0;
                        if (ses_idx >= BLOCK_BYTES)
                            ses_phase = PH_SUM;
                    end
                    PH_SUM: begin
                        if (b != ses_sum) begin
                            add_event(KIND_VERDICT, 8'd0, '0, ST_SUCCESS);
                            enter_phase(PH_RETRY, ACT_NAK);
                        end else if (ses_hdr_num == ses_last_good) begin
                            add_event(KIND_VERDICT, 8'd0, '0, ST_SUCCESS);
                            add_event(KIND_TX, BYTE_ACK, '0, ST_SUCCESS);
                            ses_retries = '0;
                            enter_phase(PH_LEAD, ACT_NONE);
                        end else if (ses_hdr_num == ses_last_good + 8'd1) begin
                            add_event(KIND_VERDICT, 8'd1, '0, ST_SUCCESS);
                            add_event(KIND_TX, BYTE_ACK, '0, ST_SUCCESS);
                            ses_last_good = ses_hdr_num;
                            ses_retries   = '0;
                            enter_phase(PH_LEAD, ACT_NONE);
                        end else begin
                            add_event(KIND_VERDICT, 8'd0, '0, ST_SUCCESS);
                            enter_phase(PH_CAN_SEQ, ACT_CAN);
                        end
                    end
                    PH_RETRY, PH_CAN_RETRY, PH_CAN_SEQ, PH_CAN_INT: ses_ticks = '0;
                    default: ;
                endcase
            end
            OP_TICK: begin
                case (ses_phase)
                    PH_LEAD: begin
                        if (tick_reaches(reg_lead))
                            enter_phase(PH_RETRY, ACT_NAK);
                    end
                    PH_HNUM, PH_HCOMP: begin
                        if (tick_reaches(reg_byte))
                            enter_phase(PH_RETRY, ACT_NAK);
                    end
                    PH_DATA, PH_SUM: begin
                        if (tick_reaches(reg_byte)) begin
                            add_event(KIND_VERDICT, 8'd0, '0, ST_SUCCESS);
                            enter_phase(PH_RETRY, ACT_NAK);
                        end
                    end
                    PH_RETRY, PH_CAN_RETRY, PH_CAN_SEQ, PH_CAN_INT: begin
                        if (tick_reaches(reg_quiet)) begin
                            case (ses_action)
                                ACT_NAK: begin
                                    add_event(KIND_TX, BYTE_NAK, '0, ST_SUCCESS);
                                    if (ses_retries != 4'hF)
                                        ses_retries++;
                                    if (ses_retries >= reg_retries)
                                        enter_phase(PH_CAN_RETRY, ACT_CAN);
                                    else
                                        enter_phase(PH_LEAD, ACT_NONE);
                                end
                                ACT_CAN: begin
                                    add_event(KIND_TX, BYTE_CAN, '0, ST_SUCCESS);
                                    ses_action = ACT_TRAILER;
                                    ses_ticks  = '0;
                                end
                                default: begin
                                    if (ses_phase == PH_CAN_RETRY)
                                        st = ST_RETRY_LIMIT;
                                    else if (ses_phase == PH_CAN_SEQ)
                                        st = ST_OUT_OF_SEQ;
                                    else
                                        st = ST_INTERRUPTED;
                                    add_event(KIND_TX, reg_trailer, '0, ST_SUCCESS);
                                    add_event(KIND_END, '0, '0, st);
                                    enter_phase(PH_IDLE, ACT_NONE);
                                end
                            endcase
                        end
                    end
                    default: ;
                endcase
            end
            default: begin
                if (ses_phase != PH_IDLE && ses_phase < PH_CAN_RETRY) begin
                    if (ses_phase == PH_DATA || ses_phase == PH_SUM)
                        add_event(KIND_VERDICT, 8'd0, '0, ST_SUCCESS);
                    enter_phase(PH_CAN_INT, ACT_CAN);
                end
            end
        endcase
        if (step_events.size() > 0)
            step_events[step_events.size()-1].last = 1'b1;
        foreach (step_events[i])
            session_events.push_back(step_events[i]);
    endfunction

    function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
        if (got !== want) begin
            $error("%s mismatch: expected 0x%0h, got 0x%0h", name, want, got);
            errors++;
        end
    endfunction

    always @(posedge aclk) begin : check_and_predict
        result_t want;
        if (aresetn) begin
            if (m_tvalid && m_tready) begin
                if (session_events.size() == 0) begin
                    $error("unexpected result transfer: kind %0d, tdata 0x%06h",
                           m_tuser, m_tdata);
                    errors++;
                end else begin
                    want = session_events.pop_front();
                    check_field("kind", want.kind, m_tuser);
                    check_field("value", want.value, m_tdata[7:0]);
                    check_field("index", want.index, m_tdata[14:8]);
                    check_field("status", want.status, m_tdata[17:15]);
                    check_field("pad", 32'd0, m_tdata[23:18]);
                    check_field("last", want.last, m_tlast);
                    results_checked++;
                end
            end
            if (s_tvalid && s_tready) begin
                advance_session(op_t'(s_tuser), s_tdata);
                items_accepted++;
                offer_taken = 1'b1;
            end
        end
    end

    always @(posedge aclk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("TB_ERROR");
            $finish;
        end
    end

    // line driver: bursts with random gaps
    always @(negedge aclk) begin : drive_line
        item_t nxt;
        if (aresetn && (!s_tvalid || offer_taken)) begin
            offer_taken = 1'b0;
            if (gap_left > 0) begin
                gap_left--;
                s_tvalid <= 1'b0;
            end else if (line_items.size() > 0) begin
                nxt = line_items.pop_front();
                s_tuser  <= nxt.operation;
                s_tdata  <= nxt.rx_byte;
                s_tvalid <= 1'b1;
                if (burst_left > 0) begin
                    burst_left--;
                end else begin
                    burst_left = $urandom_range(1, 48);
                    case ($urandom_range(0, 19))
                        0, 1, 2, 3, 4, 5: gap_left = 0;
                        6, 7, 8:          gap_left = $urandom_range(10, 30);
                        default:          gap_left = $urandom_range(1, 4);
                    endcase
                end
            end else begin
                s_tvalid <= 1'b0;
            end
        end
    end

    // result receiver: own stall pattern plus requested long hold-offs
    always @(negedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else if (holds_served != hold_requests) begin
            holds_served++;
            hold_left = LONG_HOLD;
            m_tready <= 1'b0;
        end else if (hold_left > 0) begin
            hold_left--;
            m_tready <= 1'b0;
        end else begin
            if (rx_mode_cnt == 0) begin
                rx_mode     = $urandom_range(0, 3);
                rx_mode_cnt = 50;
            end
            rx_mode_cnt--;
            case (rx_mode)
                0: m_tready <= 1'b1;
                1: m_tready <= 1'($urandom_range(0, 1));
                2: m_tready <= (rx_mode_cnt % 4 != 0);
                default: begin
                    if (rx_stall_left > 0) begin
                        rx_stall_left--;
                        m_tready <= 1'b0;
                    end else begin
                        m_tready <= 1'b1;
                        if ($urandom_range(0, 7) == 0)
                            rx_stall_left = $urandom_range(1, 12);
                    end
                end
            endcase
        end
    end

    task automatic queue_item(op_t op, logic [7:0] b);
        item_t it;
        it.operation = op;
        it.rx_byte   = b;
        line_items.push_back(it);
        items_pushed++;
    endtask

    task automatic queue_ticks(int n);
        repeat (n) queue_item(OP_TICK, 8'($urandom));
    endtask

    // sum_mode: 0 no checksum byte, 1 correct, 2 wrong
    task automatic queue_block(logic [7:0] num, logic [7:0] comp, int nbytes, int sum_mode);
        logic [7:0] sum;
        logic [7:0] b;
        int fill;
        sum  = '0;
        fill = $urandom_range(0, 9);
        if ($urandom_range(0, 5) == 0)
            queue_item(OP_BYTE, BYTE_NUL);
        queue_item(OP_BYTE, BYTE_SOH);
        queue_item(OP_BYTE, num);
        queue_item(OP_BYTE, comp);
        for (int i = 0; i < nbytes; i++) begin
            case (fill)
                0:       b = 8'h00;
                1:       b = 8'hFF;
                2:       b = 8'(i);
                default: b = 8'($urandom);
            endcase
            sum = sum + b;
            queue_item(OP_BYTE, b);
            if (reg_byte >= 16'd2 && $urandom_range(0, 49) == 0)
                queue_item(OP_TICK, 8'($urandom));
        end
        if (sum_mode == 1)
            queue_item(OP_BYTE, sum);
        else if (sum_mode == 2)
            queue_item(OP_BYTE, sum + 8'($urandom_range(1, 255)));
    endtask

    task automatic wait_sent();
        while (items_accepted != items_pushed)
            @(negedge aclk);
    endtask

    task automatic drain();
        wait_sent();
        while (session_events.size() != 0)
            @(negedge aclk);
        repeat (8) @(negedge aclk);
    endtask

    task automatic write_reg(logic [CFG_ADDR_W-1:0] addr, logic [15:0] data);
        @(negedge aclk);
        cfg_we    <= 1'b1;
        cfg_addr  <= addr;
        cfg_wdata <= data;
        case (addr)
            REG_LEAD_TIMEOUT: reg_lead    = data;
            REG_BYTE_TIMEOUT: reg_byte    = data;
            REG_QUIET:        reg_quiet   = data;
            REG_MAX_RETRIES:  reg_retries = data[3:0];
            REG_TRAILER:      reg_trailer = data[7:0];
            default: ;
        endcase
        @(negedge aclk);
        cfg_we <= 1'b0;
    endtask

    task automatic set_config(logic [15:0] lead, logic [15:0] byt, logic [15:0] quiet,
                              logic [3:0] maxr, logic [7:0] trailer);
        write_reg(REG_LEAD_TIMEOUT, lead);
        write_reg(REG_BYTE_TIMEOUT, byt);
        write_reg(REG_QUIET, quiet);
        write_reg(REG_MAX_RETRIES, {12'($urandom), maxr});
        write_reg(REG_TRAILER, {8'($urandom), trailer});
    endtask

    // one session, each segment chosen from the phase the line has reached
    task automatic run_session();
        int seg;
        int r;
        int k;
        logic [7:0] nb;
        logic [7:0] num;
        queue_item(OP_START, 8'($urandom));
        seg = 0;
        forever begin
            wait_sent();
            if (ses_phase == PH_IDLE)
                break;
            seg++;
            r = (seg > 40) ? 99 : $urandom_range(0, 99);
            case (ses_phase)
                PH_LEAD: begin
                    if (seg > 40)
                        r = 80;
                    if (r < 30) begin
                        num = ses_last_good + 8'd1;
                        queue_block(num, ~num, BLOCK_BYTES, 1);
                    end else if (r < 36) begin
                        queue_block(ses_last_good, ~ses_last_good, BLOCK_BYTES, 1);
                    end else if (r < 44) begin
                        num = ses_last_good + 8'd1;
                        queue_block(num, ~num, BLOCK_BYTES, 2);
                    end else if (r < 56) begin
                        num = ses_last_good + 8'd1;
                        case ($urandom_range(0, 5))
                            0:       queue_item(OP_BYTE, BYTE_SOH);
                            1: begin
                                queue_item(OP_BYTE, BYTE_SOH);
                                queue_item(OP_BYTE, num);
                            end
                            2:       queue_block(num, ~num, $urandom_range(0, 128), 0);
                            default: queue_block(num, ~num, $urandom_range(0, 8), 0);
                        endcase
                    end else if (r < 61) begin
                        num = 8'($urandom);
                        queue_block(num, ~num ^ 8'($urandom_range(1, 255)), 0, 0);
                    end else if (r < 66) begin
                        num = ses_last_good + 8'($urandom_range(2, 255));
                        queue_block(num, ~num, BLOCK_BYTES, 1);
                    end else if (r < 72) begin
                        do nb = 8'($urandom);
                        while (nb == BYTE_NUL || nb == BYTE_SOH || nb == BYTE_EOT ||
                               nb == BYTE_CAN);
                        queue_item(OP_BYTE, nb);
                    end else if (r < 78) begin
                        k = (reg_lead == 16'd0) ? 1 : int'(reg_lead);
                        queue_ticks($urandom_range(1, k));
                    end else if (r < 83) begin
                        queue_item(OP_ABORT, 8'($urandom));
                    end else if (r < 89) begin
                        repeat ($urandom_range(0, 2)) queue_item(OP_BYTE, BYTE_NUL);
                        queue_item(OP_BYTE, BYTE_EOT);
                    end else if (r < 92) begin
                        queue_item(OP_BYTE, BYTE_CAN);
                    end else if (r < 95) begin
                        queue_item(OP_START, 8'($urandom));
                    end else begin
                        repeat ($urandom_range(1, 3)) queue_item(OP_BYTE, BYTE_NUL);
                    end
                end
                PH_RETRY, PH_CAN_RETRY, PH_CAN_SEQ, PH_CAN_INT: begin
                    k = (reg_quiet == 16'd0) ? 1 : int'(reg_quiet);
                    if (r < 8) begin
                        queue_item(OP_ABORT, 8'($urandom));
                    end else if (r < 25) begin
                        queue_ticks($urandom_range(0, k - 1));
                        queue_item(OP_BYTE, 8'($urandom));
                    end else begin
                        queue_ticks(k);
                    end
                end
                default: begin
                    k = (reg_byte == 16'd0) ? 1 : int'(reg_byte);
                    if (r < 20)
                        queue_item(OP_ABORT, 8'($urandom));
                    else if (r < 30)
                        repeat ($urandom_range(1, 4)) queue_item(OP_BYTE, 8'($urandom));
                    else
                        queue_ticks(k);
                end
            endcase
        end
    endtask

    initial begin : stimulus
        int budget;
        int mark;

        repeat (3) @(negedge aclk);
        aresetn <= 1'b1;

        // reset register values
        queue_item(OP_START, 8'h00);
        queue_item(OP_BYTE, BYTE_NUL);
        queue_ticks(3);
        queue_block(8'h01, 8'hFE, BLOCK_BYTES, 1);
        queue_item(OP_BYTE, BYTE_EOT);
        drain();

        // directed: idle ignores, lead handling, abort paths, retry limit
        set_config(16'd2, 16'd2, 16'd1, 4'd2, 8'hFF);
        queue_item(OP_BYTE, BYTE_SOH);
        queue_item(OP_TICK, 8'hFF);
        queue_item(OP_ABORT, 8'hAA);
        queue_item(OP_START, 8'h55);
        queue_item(OP_START, 8'h00);
        queue_item(OP_BYTE, BYTE_NUL);
        queue_item(OP_BYTE, 8'h55);
        queue_item(OP_TICK, 8'h00);
        queue_item(OP_BYTE, BYTE_SOH);
        queue_item(OP_BYTE, 8'h01);
        queue_item(OP_BYTE, 8'h00);
        queue_item(OP_ABORT, 8'h00);
        queue_item(OP_TICK, 8'h00);
        queue_item(OP_ABORT, 8'h00);
        queue_item(OP_TICK, 8'h00);
        queue_item(OP_START, 8'h00);
        queue_ticks(3);
        queue_item(OP_BYTE, 8'h7F);
        queue_ticks(3);
        queue_item(OP_START, 8'h00);
        queue_item(OP_BYTE, BYTE_EOT);
        queue_item(OP_START, 8'h00);
        queue_item(OP_BYTE, BYTE_CAN);
        drain();

        // top of range: long timeouts, then fifteen retries
        set_config(16'hFFFF, 16'hFFFF, 16'd1, 4'd15, 8'h00);
        queue_item(OP_START, 8'h00);
        queue_ticks(16);
        queue_item(OP_TICK, 8'h00);
        queue_block(8'h01, 8'hFE, BLOCK_BYTES, 1);
        hold_requests++;
        queue_block(8'h01, 8'hFE, BLOCK_BYTES, 1);
        repeat (15) begin
            queue_item(OP_BYTE, 8'h55);
            queue_item(OP_TICK, 8'h00);
        end
        queue_ticks(2);
        drain();

        // long quiet time, short timeouts, good blocks only
        set_config(16'd1, 16'd1, 16'hFFFF, 4'd1, 8'hFF);
        queue_item(OP_START, 8'h00);
        queue_block(8'h01, 8'hFE, BLOCK_BYTES, 1);
        queue_block(8'h02, 8'hFD, BLOCK_BYTES, 1);
        queue_item(OP_BYTE, BYTE_EOT);
        drain();

        // zero timeouts and zero retry limit, plus writes to unused addresses
        write_reg(3'd5, 16'($urandom));
        write_reg(3'd7, 16'($urandom));
        set_config(16'd0, 16'd0, 16'd0, 4'd0, 8'h80);
        queue_item(OP_START, 8'h00);
        queue_ticks(4);
        queue_item(OP_START, 8'h00);
        queue_item(OP_BYTE, BYTE_SOH);
        queue_item(OP_TICK, 8'h00);
        queue_item(OP_ABORT, 8'h00);
        queue_ticks(2);
        drain();

        budget = 0;
        while (budget < 100) begin
            set_config(16'($urandom_range(1, 12)), 16'($urandom_range(1, 6)),
                       16'($urandom_range(1, 6)), 4'($urandom_range(1, 15)),
                       8'($urandom));
            repeat ($urandom_range(1, 2)) begin
                repeat ($urandom_range(0, 2))
                    queue_item(op_t'(2'($urandom_range(1, 3))), 8'($urandom));
                mark = items_pushed;
                run_session();
                budget += items_pushed - mark;
            end
            drain();
        end

        repeat (10) @(negedge aclk);
        $display("covered %0d transfers in, %0d results checked", items_accepted,
                 results_checked);
        $display("  %0d blocks committed, %0d sessions closed", blocks_committed,
                 sessions_closed);
        if (errors == 0 && session_events.size() == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule
